FILE: sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer: shared package
// Operation codes, character codes, field widths and the command and status
// types that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // Field widths of the two channels and the configuration register.
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Default screen geometry.
    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // A blank cell is character 0 with white-on-black attribute.
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_RESET, CHAR_NUL};

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CC_PLAIN,
        CC_NL,
        CC_TAB,
        CC_CR,
        CC_BS
    } t_ch_class;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_CR,
        CUR_BACK,
        CUR_HOME
    } t_cur_op;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC,
        PTR_IDX,
        PTR_IDX_INC
    } t_ptr_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CHAR,
        WR_BLANK,
        WR_COPY
    } t_wr_sel;

    typedef enum logic [2:0] {
        RA_PTR,
        RA_PTR_INC,
        RA_PTR_DEC,
        RA_PTR_ROW,
        RA_IDX,
        RA_REQ
    } t_ra_sel;

    typedef struct packed {
        logic    in_ready;
        logic    ld_item;
        t_cur_op cur_op;
        t_ptr_op ptr_op;
        t_wr_sel wr_sel;
        logic    rd_en;
        t_ra_sel ra_sel;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic      in_fire;
        t_op       op;
        t_ch_class ch_class;
        logic      adv_scroll;
        logic      nl_scroll;
        logic      idx_last;
        logic      ptr_last;
        logic      ptr_scroll_last;
        logic      ptr_at_idx;
        logic      rd_zero;
        logic      out_free;
    } t_dp_stat;

endpackage

FILE: sv/tccw_in_if.sv
// ----------------------------------------------------------------------------
// Text console character writer: request channel
// Valid/ready channel that carries one operation request per transfer.
// ----------------------------------------------------------------------------
interface tccw_in_if
    import tccw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] character;
    logic [COL_W-1:0]  read_column;
    logic [ROW_W-1:0]  read_row;

    modport source (
        output valid, operation, character, read_column, read_row,
        input  ready
    );

    modport sink (
        input  valid, operation, character, read_column, read_row,
        output ready
    );
endinterface

FILE: sv/tccw_out_if.sv
// ----------------------------------------------------------------------------
// Text console character writer: result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface tccw_out_if
    import tccw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0] cell_character;
    logic [ATTR_W-1:0] cell_attribute;

    modport source (
        output valid, cursor_column, cursor_row, cell_character, cell_attribute,
        input  ready
    );

    modport sink (
        input  valid, cursor_column, cursor_row, cell_character, cell_attribute,
        output ready
    );
endinterface

FILE: sv/tccw_datapath.sv
// ----------------------------------------------------------------------------
// Text console character writer: datapath
// Screen memory, cursor, walk pointer, request latch, attribute register and
// the result register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module tccw_datapath
    import tccw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ATTR_W-1:0] i_cfg_wr_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    tccw_in_if.sink           i_in,
    tccw_out_if.source        o_out
);
    localparam int N  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW = $clog2(N);
    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);

    localparam logic [AW-1:0] LAST_CELL   = AW'(N - 1);
    localparam logic [AW-1:0] LAST_ROW    = AW'(N - SCREEN_WIDTH);
    localparam logic [AW-1:0] SCROLL_LAST = AW'(N - SCREEN_WIDTH - 1);
    localparam logic [AW-1:0] ROW_STEP    = AW'(SCREEN_WIDTH);
    localparam logic [XW-1:0] X_LAST      = XW'(SCREEN_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST      = YW'(SCREEN_HEIGHT - 1);

    logic [CELL_W-1:0] r_mem [N];
    logic [CELL_W-1:0] r_rd;

    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_ptr, n_ptr;

    t_op               r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [COL_W-1:0]  r_rc;
    logic [ROW_W-1:0]  r_rr;
    logic [ATTR_W-1:0] r_attr;

    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;

    logic              req_ok;
    logic [AW-1:0]     req_addr;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [CHAR_W-1:0] put_char;
    logic              x_last;
    logic              y_last;
    t_ch_class         ch_class;
    logic              out_cell;

    assign x_last   = (r_x == X_LAST);
    assign y_last   = (r_y == Y_LAST);
    assign req_ok   = (32'(r_rc) < SCREEN_WIDTH) && (32'(r_rr) < SCREEN_HEIGHT);
    assign req_addr = AW'(32'(r_rr) * SCREEN_WIDTH + 32'(r_rc));
    assign put_char = (r_ch == CHAR_TAB) ? CHAR_SPACE : r_ch;
    assign out_cell = (r_op == OP_READ) && req_ok;

    always_comb begin
        case (r_ch)
            CHAR_NL:  ch_class = CC_NL;
            CHAR_TAB: ch_class = CC_TAB;
            CHAR_CR:  ch_class = CC_CR;
            CHAR_BS:  ch_class = CC_BS;
            default:  ch_class = CC_PLAIN;
        endcase
    end

    // Cursor update. The linear index is kept alongside x and y.
    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_idx = r_idx;
        case (i_cmd.cur_op)
            CUR_ADVANCE: begin
                if (x_last) begin
                    n_x = '0;
                    if (y_last) begin
                        n_idx = LAST_ROW;
                    end else begin
                        n_y   = r_y + YW'(1);
                        n_idx = r_idx + AW'(1);
                    end
                end else begin
                    n_x   = r_x + XW'(1);
                    n_idx = r_idx + AW'(1);
                end
            end
            CUR_NEWLINE: begin
                n_x = '0;
                if (y_last) begin
                    n_idx = LAST_ROW;
                end else begin
                    n_y   = r_y + YW'(1);
                    n_idx = r_idx - AW'(r_x) + ROW_STEP;
                end
            end
            CUR_CR: begin
                n_x   = '0;
                n_idx = r_idx - AW'(r_x);
            end
            CUR_BACK: begin
                if (r_x != '0) begin
                    n_x   = r_x - XW'(1);
                    n_idx = r_idx - AW'(1);
                end else if (r_y != '0) begin
                    n_y   = r_y - YW'(1);
                    n_x   = X_LAST;
                    n_idx = r_idx - AW'(1);
                end
            end
            CUR_HOME: begin
                n_x   = '0;
                n_y   = '0;
                n_idx = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_ZERO:    n_ptr = '0;
            PTR_INC:     n_ptr = r_ptr + AW'(1);
            PTR_DEC:     n_ptr = r_ptr - AW'(1);
            PTR_IDX:     n_ptr = r_idx;
            PTR_IDX_INC: n_ptr = r_idx + AW'(1);
            default:     n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.ra_sel)
            RA_PTR_INC: rd_addr = r_ptr + AW'(1);
            RA_PTR_DEC: rd_addr = r_ptr - AW'(1);
            RA_PTR_ROW: rd_addr = r_ptr + ROW_STEP;
            RA_IDX:     rd_addr = r_idx;
            RA_REQ:     rd_addr = req_addr;
            default:    rd_addr = r_ptr;
        endcase
    end

    // A read request outside the screen never touches the memory.
    assign rd_en = i_cmd.rd_en && ((i_cmd.ra_sel != RA_REQ) || req_ok);

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_ptr;
        wr_data = r_rd;
        case (i_cmd.wr_sel)
            WR_CHAR: begin
                wr_addr = r_idx;
                wr_data = {r_attr, put_char};
            end
            WR_BLANK: wr_data = BLANK_CELL;
            WR_COPY:  wr_data = r_rd;
            default:  wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_idx       <= '0;
            r_ptr       <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_idx <= n_idx;
            r_ptr <= n_ptr;
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item && i_in.valid) begin
            r_op <= t_op'(i_in.operation);
            r_ch <= i_in.character;
            r_rc <= i_in.read_column;
            r_rr <= i_in.read_row;
        end
        if (i_cmd.out_load) begin
            r_out_col  <= COL_W'(r_x);
            r_out_row  <= ROW_W'(r_y);
            r_out_char <= out_cell ? r_rd[CHAR_W-1:0] : CHAR_NUL;
            r_out_attr <= out_cell ? r_rd[CELL_W-1:CHAR_W] : '0;
        end
    end

    assign i_in.ready           = i_cmd.in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.cursor_column  = r_out_col;
    assign o_out.cursor_row     = r_out_row;
    assign o_out.cell_character = r_out_char;
    assign o_out.cell_attribute = r_out_attr;

    always_comb begin
        o_stat.in_fire         = i_in.valid && i_cmd.in_ready;
        o_stat.op              = r_op;
        o_stat.ch_class        = ch_class;
        o_stat.adv_scroll      = x_last && y_last;
        o_stat.nl_scroll       = y_last;
        o_stat.idx_last        = (r_idx == LAST_CELL);
        o_stat.ptr_last        = (r_ptr == LAST_CELL);
        o_stat.ptr_scroll_last = (r_ptr == SCROLL_LAST);
        o_stat.ptr_at_idx      = (r_ptr == r_idx);
        o_stat.rd_zero         = (r_rd[CHAR_W-1:0] == CHAR_NUL);
        o_stat.out_free        = !r_out_valid || o_out.ready;
    end

endmodule

FILE: sv/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console character writer: controller
// Sequences each operation as a series of single-cell memory steps.
// ----------------------------------------------------------------------------
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_DISPATCH,
        S_PUT,
        S_SCR_RD,
        S_SCR_WR,
        S_SCR_FILL,
        S_CLR_FILL,
        S_FIND,
        S_FIND_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_BS_LOAD,
        S_BS_CHK,
        S_BS_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_tab_more, n_tab_more;

    always_comb begin
        n_state    = r_state;
        n_tab_more = r_tab_more;
        o_cmd      = '{in_ready: 1'b0, ld_item: 1'b0, cur_op: CUR_HOLD,
                       ptr_op: PTR_HOLD, wr_sel: WR_NONE, rd_en: 1'b0,
                       ra_sel: RA_PTR, out_load: 1'b0};
        case (r_state)
            S_BOOT: begin
                o_cmd.wr_sel = WR_BLANK;
                o_cmd.ptr_op = PTR_INC;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_op = PTR_ZERO;
                    n_state      = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.ld_item  = 1'b1;
                if (i_stat.in_fire) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_READ: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.ra_sel = RA_REQ;
                        n_state      = S_DONE;
                    end
                    OP_CLEAR: begin
                        o_cmd.cur_op = CUR_HOME;
                        o_cmd.ptr_op = PTR_ZERO;
                        n_state      = S_CLR_FILL;
                    end
                    default: begin
                        case (i_stat.ch_class)
                            CC_NL: begin
                                o_cmd.cur_op = CUR_NEWLINE;
                                if (i_stat.nl_scroll) begin
                                    o_cmd.ptr_op = PTR_ZERO;
                                    n_state      = S_SCR_RD;
                                end else begin
                                    n_state = S_DONE;
                                end
                            end
                            CC_CR: begin
                                o_cmd.cur_op = CUR_CR;
                                n_state      = S_DONE;
                            end
                            CC_BS: begin
                                o_cmd.cur_op = CUR_BACK;
                                n_state      = S_BS_LOAD;
                            end
                            CC_TAB: begin
                                n_tab_more = 1'b1;
                                n_state    = S_PUT;
                            end
                            default: begin
                                if (i_stat.op == OP_INSERT && !i_stat.idx_last) begin
                                    o_cmd.ptr_op = PTR_IDX_INC;
                                    n_state      = S_FIND;
                                end else begin
                                    n_state = S_PUT;
                                end
                            end
                        endcase
                    end
                endcase
            end
            S_PUT: begin
                o_cmd.wr_sel = WR_CHAR;
                o_cmd.cur_op = CUR_ADVANCE;
                if (i_stat.adv_scroll) begin
                    o_cmd.ptr_op = PTR_ZERO;
                    n_state      = S_SCR_RD;
                end else if (r_tab_more) begin
                    n_tab_more = 1'b0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.ra_sel = RA_PTR_ROW;
                n_state      = S_SCR_WR;
            end
            S_SCR_WR: begin
                o_cmd.wr_sel = WR_COPY;
                o_cmd.ptr_op = PTR_INC;
                n_state      = i_stat.ptr_scroll_last ? S_SCR_FILL : S_SCR_RD;
            end
            S_SCR_FILL: begin
                o_cmd.wr_sel = WR_BLANK;
                o_cmd.ptr_op = PTR_INC;
                if (i_stat.ptr_last) begin
                    if (r_tab_more) begin
                        n_tab_more = 1'b0;
                        n_state    = S_PUT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLR_FILL: begin
                o_cmd.wr_sel = WR_BLANK;
                o_cmd.ptr_op = PTR_INC;
                if (i_stat.ptr_last) begin
                    n_state = S_DONE;
                end
            end
            S_FIND: begin
                if (i_stat.ptr_last) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ra_sel = RA_PTR;
                    n_state      = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (i_stat.rd_zero) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                    n_state      = S_FIND;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.ptr_at_idx) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ra_sel = RA_PTR_DEC;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_sel = WR_COPY;
                o_cmd.ptr_op = PTR_DEC;
                n_state      = S_SHIFT_RD;
            end
            S_BS_LOAD: begin
                o_cmd.ptr_op = PTR_IDX;
                o_cmd.rd_en  = 1'b1;
                o_cmd.ra_sel = RA_IDX;
                n_state      = S_BS_CHK;
            end
            S_BS_CHK: begin
                if (i_stat.rd_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.ptr_last) begin
                    o_cmd.wr_sel = WR_BLANK;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ra_sel = RA_PTR_INC;
                    n_state      = S_BS_WR;
                end
            end
            S_BS_WR: begin
                o_cmd.wr_sel = WR_COPY;
                o_cmd.ptr_op = PTR_INC;
                n_state      = S_BS_CHK;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_BOOT;
            r_tab_more <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tab_more <= n_tab_more;
        end
    end

endmodule

FILE: sv/text_console_char_writer_top.sv
// ----------------------------------------------------------------------------
// Text console character writer: top level
// Text screen of character/attribute cells with a cursor.
// ----------------------------------------------------------------------------
// Requests arrive on i_in, one per transfer, and each one produces exactly one
// result transfer on o_out carrying the cursor position after the operation
// and, for a read, the selected cell (zero otherwise). i_cfg_wr_en with
// i_cfg_wr_data sets the attribute stored with new characters; write it only
// while no request is in flight.
// The block works on one request at a time. A plain put writes the character
// and advances the cursor; a carriage return or a non-scrolling newline only
// moves the cursor. i_in.ready rises again in the cycle after a result is
// loaded. A clear blanks every cell in turn. A scroll copies each cell above
// the bottom row from the cell below it and then blanks the bottom row. An
// insert finds the first empty cell after the cursor and shifts the cells up
// to it one place right; a backspace shifts the cells from the cursor one
// place left as far as an empty cell. After reset the block blanks the memory,
// one cell per cycle, before it raises i_in.ready. If the receiver stalls, the
// next request is still taken and waits for the output register to drain.
// ----------------------------------------------------------------------------
module text_console_char_writer_top
    import tccw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ATTR_W-1:0] i_cfg_wr_data,
    tccw_in_if.sink           i_in,
    tccw_out_if.source        o_out
);
    // Commands flow from the controller to the datapath; status flows back.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    tccw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tccw_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in          (i_in),
        .o_out         (o_out)
    );

endmodule
